// File: sv/dgft_pkg.sv
`timescale 1ns / 1ps

package dgft_pkg;

    // Fixed-point constants
    localparam logic [15:0] ENV_DECAY   = 16'd58982;   // 0.9
    localparam logic [15:0] BIN_DECAY   = 16'd65405;   // 0.998
    localparam logic [15:0] DENSE_FRAC  = 16'd26214;   // 0.4
    localparam logic [11:0] SMOOTH_GAIN = 12'd3277;    // 0.05
    localparam logic [15:0] BPM_MIN     = 16'd128;     // 1.0 bpm
    localparam logic [15:0] CONF_MIN    = 16'd16384;   // 0.25
    localparam logic [7:0]  RATE_DEF    = 8'd30;
    localparam logic [31:0] PER_SCALE   = 32'd7864320; // 240 * 2^15
    localparam logic [24:0] PHASE_STEP  = 25'd256;     // one frame in Q16.8

    localparam logic [5:0]  DIV_INT_STEPS  = 6'd32;
    localparam logic [5:0]  DIV_FRAC_STEPS = 6'd16;

    typedef enum logic [2:0] {
        DIV_NONE,
        DIV_PERIOD,
        DIV_MOD,
        DIV_BIN,
        DIV_SYNC,
        DIV_BACK
    } t_div_sel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PER_GO,
        S_PER_WAIT,
        S_MOD_CHK,
        S_MOD_WAIT,
        S_BIN_GO,
        S_BIN_WAIT,
        S_SCAN_A,
        S_DRAIN_A,
        S_SCAN_B,
        S_DRAIN_B,
        S_SYNC_GO,
        S_SYNC_WAIT,
        S_BACK_GO,
        S_BACK_WAIT,
        S_SMOOTH,
        S_OUT
    } t_state;

    typedef struct packed {
        logic     capture;
        logic     div_go;
        logic     div_take;
        t_div_sel div_sel;
        logic     rd_a;
        logic     rd_b;
        logic     prep;
        logic     smooth;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic trust;
        logic need_mod;
        logic div_done;
        logic pipe_idle;
        logic out_free;
    } t_status;

endpackage

// File: sv/dgft_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
// Integer mode: remainder starts at zero, dividend shifts in over 32 steps.
// Fraction mode: remainder starts at the numerator, zeros shift in.
module dgft_div
    import dgft_pkg::*;
#(
    parameter int TW = 36
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic          i_frac,
    input  logic [31:0]   i_n,
    input  logic [TW-1:0] i_d,
    input  logic [TW-1:0] i_r0,
    output logic          o_busy,
    output logic          o_done,
    output logic [31:0]   o_q,
    output logic [TW-1:0] o_r
);

    logic [TW-1:0] r_r;
    logic [31:0]   r_q;
    logic [TW-1:0] r_d;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [TW:0]   w_sh;
    logic          w_ge;

    assign w_sh = {r_r, r_q[31]};
    assign w_ge = w_sh >= {1'b0, r_d};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= i_frac ? DIV_FRAC_STEPS : DIV_INT_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_r <= i_r0;
            r_q <= i_n;
            r_d <= i_d;
        end else if (r_busy) begin
            r_r <= w_ge ? TW'(w_sh - {1'b0, r_d}) : w_sh[TW-1:0];
            r_q <= {r_q[30:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_q    = r_q;
    assign o_r    = r_r;

endmodule

// File: sv/dgft_dp.sv
`timescale 1ns / 1ps

module dgft_dp
    import dgft_pkg::*;
#(
    parameter int NUM_BINS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    input  logic [$clog2(NUM_BINS)-1:0] i_idx,
    input  logic [15:0]                 i_kick,
    input  logic [15:0]                 i_snare,
    input  logic [15:0]                 i_bpm,
    input  logic [15:0]                 i_bpm_confidence,
    input  logic [7:0]                  i_rate,
    input  logic                        i_stall,
    output t_status                     o_status,
    output logic                        o_valid,
    output logic [15:0]                 o_syncopation,
    output logic [15:0]                 o_backbeat,
    output logic [15:0]                 o_kick_density
);

    localparam int BW = $clog2(NUM_BINS);
    localparam int TW = 32 + BW;

    function automatic logic [15:0] env_next(input logic [15:0] env, input logic [15:0] x);
        logic [31:0] p;
        logic [15:0] h;
        p = env * ENV_DECAY;
        h = 16'((x - env) >> 1);
        return (x > env) ? 16'(env + h) : p[31:16];
    endfunction

    function automatic logic [15:0] ratio(input logic [TW-1:0] num, input logic [TW-1:0] den,
                                          input logic [31:0] q);
        if (den == '0)
            return 16'd0;
        if (num >= den)
            return 16'hFFFF;
        return q[15:0];
    endfunction

    function automatic logic [15:0] smooth(input logic [15:0] lvl, input logic [15:0] tgt);
        logic [15:0] d;
        logic [28:0] p;
        d = (tgt >= lvl) ? 16'(tgt - lvl) : 16'(lvl - tgt);
        p = 29'(d * SMOOTH_GAIN) + 29'd32768;
        return (tgt >= lvl) ? 16'(lvl + 16'(p[28:16])) : 16'(lvl - 16'(p[28:16]));
    endfunction

    // frame registers
    logic [15:0]   r_kenv, r_senv, r_bpm;
    logic          r_trust;
    logic [23:0]   r_phase;
    logic [24:0]   r_ph_tmp, r_period;
    logic [BW-1:0] r_bin;

    // histogram memories and valid bits
    logic [31:0]       r_kmem [NUM_BINS];
    logic [31:0]       r_smem [NUM_BINS];
    logic [NUM_BINS-1:0] r_hv;
    logic [31:0]       r_rdk, r_rds;
    logic              r_rdv;

    // scan pipeline
    logic          r_s1a, r_s1b, r_s2;
    logic [BW-1:0] r_s1idx, r_s2idx;
    logic [31:0]   r_s2k, r_s2s;

    // accumulators
    logic [TW-1:0] r_ktot, r_stot, r_koff, r_soff, r_sbeat;
    logic [31:0]   r_kmax;
    logic [BW-1:0] r_pivot, r_dense;
    logic [46:0]   r_kthr;

    // targets, levels, output
    logic [15:0] r_sync_t, r_back_t;
    logic [15:0] r_sync_l, r_back_l, r_dens_l;
    logic        r_ovalid;
    logic [15:0] r_osync, r_oback, r_odens;

    // divider hookup
    logic          w_dgo, w_dfrac, w_dbusy, w_ddone;
    logic [31:0]   w_dn, w_dq;
    logic [TW-1:0] w_dd, w_dr0, w_drem, w_sbmax;

    logic [7:0]    w_rate;
    logic [BW:0]   w_rsum;
    logic [BW-1:0] w_raddr;
    logic          w_rd;

    assign w_rate  = (i_rate == 8'd0) ? RATE_DEF : i_rate;
    assign w_sbmax = (r_sbeat > r_soff) ? r_sbeat : r_soff;
    assign w_dgo   = i_cmd.div_go;

    // divider operand select
    always_comb begin
        w_dfrac = 1'b0;
        w_dn    = '0;
        w_dd    = '0;
        w_dr0   = '0;
        case (i_cmd.div_sel)
            DIV_PERIOD: begin
                w_dn = 32'(w_rate * PER_SCALE);
                w_dd = TW'(r_bpm);
            end
            DIV_MOD: begin
                w_dn = 32'(r_ph_tmp);
                w_dd = TW'(r_period);
            end
            DIV_BIN: begin
                w_dn = 32'(32'(r_ph_tmp) * 32'(NUM_BINS));
                w_dd = TW'(r_period);
            end
            DIV_SYNC: begin
                w_dfrac = 1'b1;
                w_dd    = r_ktot;
                w_dr0   = r_koff;
            end
            DIV_BACK: begin
                w_dfrac = 1'b1;
                w_dd    = r_stot;
                w_dr0   = w_sbmax;
            end
            default: begin
                w_dfrac = 1'b0;
            end
        endcase
    end

    dgft_div #(
        .TW(TW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (w_dgo),
        .i_frac (w_dfrac),
        .i_n    (w_dn),
        .i_d    (w_dd),
        .i_r0   (w_dr0),
        .o_busy (w_dbusy),
        .o_done (w_ddone),
        .o_q    (w_dq),
        .o_r    (w_drem)
    );

    // frame capture, phase and divider results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kenv  <= '0;
            r_senv  <= '0;
            r_phase <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_kenv <= env_next(r_kenv, i_kick);
                r_senv <= env_next(r_senv, i_snare);
            end
            if (i_cmd.div_go && i_cmd.div_sel == DIV_BIN)
                r_phase <= r_ph_tmp[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_bpm    <= i_bpm;
            r_trust  <= (i_bpm > BPM_MIN) && (i_bpm_confidence > CONF_MIN);
            r_ph_tmp <= {1'b0, r_phase} + PHASE_STEP;
        end
        if (i_cmd.div_take) begin
            case (i_cmd.div_sel)
                DIV_PERIOD: r_period <= w_dq[24:0];
                DIV_MOD:    r_ph_tmp <= w_drem[24:0];
                DIV_BIN:    r_bin    <= w_dq[BW-1:0];
                DIV_SYNC:   r_sync_t <= ratio(r_koff, r_ktot, w_dq);
                DIV_BACK:   r_back_t <= ratio(w_sbmax, r_stot, w_dq);
                default:    r_bin    <= r_bin;
            endcase
        end
    end

    // rotated read address for the second pass
    assign w_rsum  = {1'b0, i_idx} + {1'b0, r_pivot};
    assign w_rd    = i_cmd.rd_a || i_cmd.rd_b;
    assign w_raddr = i_cmd.rd_a ? i_idx :
                     ((w_rsum >= (BW+1)'(NUM_BINS)) ? BW'(w_rsum - (BW+1)'(NUM_BINS))
                                                    : w_rsum[BW-1:0]);

    // histogram memories
    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_rdk <= r_kmem[w_raddr];
            r_rds <= r_smem[w_raddr];
        end
        if (r_s2) begin
            r_kmem[r_s2idx] <= r_s2k;
            r_smem[r_s2idx] <= r_s2s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv  <= '0;
            r_rdv <= 1'b0;
        end else begin
            if (w_rd)
                r_rdv <= r_hv[w_raddr];
            if (r_s2)
                r_hv[r_s2idx] <= 1'b1;
        end
    end

    // scan pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1a <= 1'b0;
            r_s1b <= 1'b0;
            r_s2  <= 1'b0;
        end else begin
            r_s1a <= i_cmd.rd_a;
            r_s1b <= i_cmd.rd_b;
            r_s2  <= r_s1a;
        end
    end

    // first pass: accumulate at the phase bin, decay, then totals and pivot
    logic [31:0] w_k1, w_s1, w_ka, w_sa;
    logic [32:0] w_ksum, w_ssum;
    logic [47:0] w_kdec, w_sdec;
    logic        w_hit;

    assign w_k1   = r_rdv ? r_rdk : 32'd0;
    assign w_s1   = r_rdv ? r_rds : 32'd0;
    assign w_hit  = r_trust && (r_s1idx == r_bin);
    assign w_ksum = {1'b0, w_k1} + {1'b0, r_kenv, 16'h0000};
    assign w_ssum = {1'b0, w_s1} + {1'b0, r_senv, 16'h0000};
    assign w_ka   = !w_hit ? w_k1 : (w_ksum[32] ? 32'hFFFF_FFFF : w_ksum[31:0]);
    assign w_sa   = !w_hit ? w_s1 : (w_ssum[32] ? 32'hFFFF_FFFF : w_ssum[31:0]);
    assign w_kdec = w_ka * BIN_DECAY;
    assign w_sdec = w_sa * BIN_DECAY;

    always_ff @(posedge i_clk) begin
        if (w_rd)
            r_s1idx <= i_idx;
        r_s2idx <= r_s1idx;
        r_s2k   <= w_kdec[47:16];
        r_s2s   <= w_sdec[47:16];
    end

    // accumulators over both passes
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ktot  <= '0;
            r_stot  <= '0;
            r_kmax  <= '0;
            r_pivot <= '0;
            r_koff  <= '0;
            r_soff  <= '0;
            r_sbeat <= '0;
            r_dense <= '0;
        end else begin
            if (r_s2) begin
                r_ktot <= r_ktot + TW'(r_s2k);
                r_stot <= r_stot + TW'(r_s2s);
                if (r_s2k > r_kmax) begin
                    r_kmax  <= r_s2k;
                    r_pivot <= r_s2idx;
                end
            end
            if (r_s1b) begin
                if (r_s1idx[1:0] == 2'd2) begin
                    r_koff <= r_koff + TW'(w_k1);
                    r_soff <= r_soff + TW'(w_s1);
                end
                if (r_s1idx[2:0] == 3'd4)
                    r_sbeat <= r_sbeat + TW'(w_s1);
                if (r_s1idx[1:0] == 2'd0 && {w_k1, 16'h0000} > {1'b0, r_kthr})
                    r_dense <= r_dense + BW'(1);
            end
        end
        if (i_cmd.prep)
            r_kthr <= 47'(r_kmax * DENSE_FRAC[14:0]);
    end

    // smoothing and output register
    logic [15:0] w_dtgt;
    assign w_dtgt = (r_dense >= BW'(4)) ? 16'hFFFF : 16'({r_dense, 14'h0000});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_l <= '0;
            r_back_l <= '0;
            r_dens_l <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.smooth) begin
                r_sync_l <= smooth(r_sync_l, r_sync_t);
                if (r_stot != '0)
                    r_back_l <= smooth(r_back_l, r_back_t);
                r_dens_l <= smooth(r_dens_l, w_dtgt);
            end
            if (i_cmd.out_load)
                r_ovalid <= 1'b1;
            else if (!i_stall)
                r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_osync <= r_sync_l;
            r_oback <= r_back_l;
            r_odens <= r_dens_l;
        end
    end

    assign o_status.trust     = r_trust;
    assign o_status.need_mod  = r_ph_tmp >= r_period;
    assign o_status.div_done  = w_ddone;
    assign o_status.pipe_idle = !r_s1a && !r_s1b && !r_s2;
    assign o_status.out_free  = !r_ovalid || !i_stall;

    assign o_valid        = r_ovalid;
    assign o_syncopation  = r_osync;
    assign o_backbeat     = r_oback;
    assign o_kick_density = r_odens;

    // checks
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_go |-> !w_dbusy)
        else $error("divider started while busy");
    a_one_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.rd_a && i_cmd.rd_b))
        else $error("both scan passes issued");
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_ovalid || !i_stall))
        else $error("output register overwritten");
    a_wb_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2 |-> $past(r_s1a))
        else $error("writeback without first-pass read");

endmodule

// File: sv/dgft_ctrl.sv
`timescale 1ns / 1ps

module dgft_ctrl
    import dgft_pkg::*;
#(
    parameter int NUM_BINS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  t_status                     i_status,
    output logic                        o_stall,
    output t_cmd                        o_cmd,
    output logic [$clog2(NUM_BINS)-1:0] o_idx
);

    localparam int BW = $clog2(NUM_BINS);
    localparam logic [BW-1:0] LAST = BW'(NUM_BINS - 1);

    t_state        r_state, n_state;
    logic [BW-1:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE:      if (i_valid) n_state = S_PER_GO;
            S_PER_GO:    n_state = i_status.trust ? S_PER_WAIT : S_SCAN_A;
            S_PER_WAIT:  if (i_status.div_done) n_state = S_MOD_CHK;
            S_MOD_CHK:   n_state = i_status.need_mod ? S_MOD_WAIT : S_BIN_GO;
            S_MOD_WAIT:  if (i_status.div_done) n_state = S_BIN_GO;
            S_BIN_GO:    n_state = S_BIN_WAIT;
            S_BIN_WAIT:  if (i_status.div_done) n_state = S_SCAN_A;
            S_SCAN_A: begin
                n_idx = r_idx + BW'(1);
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = S_DRAIN_A;
                end
            end
            S_DRAIN_A:   if (i_status.pipe_idle) n_state = S_SCAN_B;
            S_SCAN_B: begin
                n_idx = r_idx + BW'(1);
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = S_DRAIN_B;
                end
            end
            S_DRAIN_B:   if (i_status.pipe_idle) n_state = S_SYNC_GO;
            S_SYNC_GO:   n_state = S_SYNC_WAIT;
            S_SYNC_WAIT: if (i_status.div_done) n_state = S_BACK_GO;
            S_BACK_GO:   n_state = S_BACK_WAIT;
            S_BACK_WAIT: if (i_status.div_done) n_state = S_SMOOTH;
            S_SMOOTH:    n_state = S_OUT;
            S_OUT:       if (i_status.out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = DIV_NONE;
        case (r_state)
            S_IDLE:      o_cmd.capture = i_valid;
            S_PER_GO: begin
                o_cmd.div_sel = DIV_PERIOD;
                o_cmd.div_go  = i_status.trust;
            end
            S_PER_WAIT: begin
                o_cmd.div_sel  = DIV_PERIOD;
                o_cmd.div_take = i_status.div_done;
            end
            S_MOD_CHK: begin
                o_cmd.div_sel = DIV_MOD;
                o_cmd.div_go  = i_status.need_mod;
            end
            S_MOD_WAIT: begin
                o_cmd.div_sel  = DIV_MOD;
                o_cmd.div_take = i_status.div_done;
            end
            S_BIN_GO: begin
                o_cmd.div_sel = DIV_BIN;
                o_cmd.div_go  = 1'b1;
            end
            S_BIN_WAIT: begin
                o_cmd.div_sel  = DIV_BIN;
                o_cmd.div_take = i_status.div_done;
            end
            S_SCAN_A:    o_cmd.rd_a = 1'b1;
            S_DRAIN_A:   o_cmd.prep = i_status.pipe_idle;
            S_SCAN_B:    o_cmd.rd_b = 1'b1;
            S_SYNC_GO: begin
                o_cmd.div_sel = DIV_SYNC;
                o_cmd.div_go  = 1'b1;
            end
            S_SYNC_WAIT: begin
                o_cmd.div_sel  = DIV_SYNC;
                o_cmd.div_take = i_status.div_done;
            end
            S_BACK_GO: begin
                o_cmd.div_sel = DIV_BACK;
                o_cmd.div_go  = 1'b1;
            end
            S_BACK_WAIT: begin
                o_cmd.div_sel  = DIV_BACK;
                o_cmd.div_take = i_status.div_done;
            end
            S_SMOOTH:    o_cmd.smooth   = 1'b1;
            S_OUT:       o_cmd.out_load = i_status.out_free;
            default:     o_cmd.capture  = 1'b0;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_idx   = r_idx;

endmodule

// File: sv/drum_groove_feature_tracker.sv
// With trusted tempo, each frame runs a 32-step period division and a 32-step bin division,
// plus a third 32-step division when the phase wraps; untrusted tempo skips all three.
// Two 16-step ratio divisions and two one-bin-per-cycle histogram scans every frame.
// One frame at a time: the next frame can be taken in the cycle after the result is loaded;
// the load waits while i_stall holds a previous result; divisions share one bit-serial divider.
// Reset (synchronous, active low) clears envelopes, phase, levels, histogram valid bits
// and sets analysis_rate to 30; no clearing pass is needed.
`timescale 1ns / 1ps

module drum_groove_feature_tracker
    import dgft_pkg::*;
#(
    parameter int NUM_BINS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_kick,
    input  logic [15:0] i_snare,
    input  logic [15:0] i_bpm,
    input  logic [15:0] i_bpm_confidence,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_syncopation,
    output logic [15:0] o_backbeat,
    output logic [15:0] o_kick_density,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int BW = $clog2(NUM_BINS);

    logic [7:0]    r_rate;
    t_cmd          w_cmd;
    t_status       w_status;
    logic [BW-1:0] w_idx;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_DEF;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_rate <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {24'd0, r_rate};

    dgft_ctrl #(
        .NUM_BINS(NUM_BINS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_status(w_status),
        .o_stall (o_stall),
        .o_cmd   (w_cmd),
        .o_idx   (w_idx)
    );

    dgft_dp #(
        .NUM_BINS(NUM_BINS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_idx           (w_idx),
        .i_kick          (i_kick),
        .i_snare         (i_snare),
        .i_bpm           (i_bpm),
        .i_bpm_confidence(i_bpm_confidence),
        .i_rate          (r_rate),
        .i_stall         (i_stall),
        .o_status        (w_status),
        .o_valid         (o_valid),
        .o_syncopation   (o_syncopation),
        .o_backbeat      (o_backbeat),
        .o_kick_density  (o_kick_density)
    );

endmodule
